### src/sqd_pkg.sv
package sqd_pkg;

   localparam int MAX_SIDE = 256;
   localparam int COORD_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W   = COORD_W + 1;
   localparam int ADDR_W   = 2 * COORD_W;
   localparam int PIXEL_W  = 8;

   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_DRAW  = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [1:0] STYLE_OUTLINE = 2'd1;
   localparam logic [1:0] STYLE_FILL    = 2'd2;

   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] center_row;
      logic [7:0] center_col;
      logic [6:0] radius;
      logic [1:0] style;
      logic [7:0] color;
   } sqd_req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] pixel;
   } sqd_rsp_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [PIXEL_W-1:0]    wr_data;
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
   } sqd_mem_ctl_type;

endpackage

### src/sqd_image_mem.sv
module sqd_image_mem (
   input  logic                              clock,
   input  sqd_pkg::sqd_mem_ctl_type          ctl,
   output logic [sqd_pkg::PIXEL_W-1:0]       rd_data
);
   import sqd_pkg::*;

   logic [PIXEL_W-1:0] image_mem [0:(2**ADDR_W)-1];
   logic [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         image_mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= image_mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/square_draw_framebuffer_top.sv
// Channel   Handshake                    Payload
// request   start, busy                  req_item  (sqd_req_type)
// response  rsp_strobe (one cycle)       rsp_item  (sqd_rsp_type)
// config    csr_valid, csr_ready         csr_data  (image side, 9 bits)
//
// An item is taken when start is high and busy is low; busy then stays high through
// the response cycle. Clears and squares are walked pixel by pixel through the
// single write port of the image memory, one pixel per cycle; a read or a rejected
// command writes no pixel.
// Synchronous reset returns the controller to idle and the side to 256; image contents
// are undefined until written. The receiver cannot stall the response.
module square_draw_framebuffer_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  sqd_pkg::sqd_req_type     req_item,
   output logic                     rsp_strobe,
   output sqd_pkg::sqd_rsp_type     rsp_item,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [sqd_pkg::SIDE_W-1:0] csr_data
);
   import sqd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_WALK  = 5'b00100,
      S_READ  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   sqd_req_type        cmd_ff;
   logic [SIDE_W-1:0]  side_ff;
   logic [SIDE_W-1:0]  side_eff;
   logic [COORD_W-1:0] r0_ff, r0_in, r1_ff, r1_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [COORD_W-1:0] i_ff, i_in, j_ff, j_in;
   logic               outline_ff, outline_in;
   logic               status_ff, status_in;
   logic               pix_sel_ff, pix_sel_in;
   logic               reject;
   logic [SIDE_W-1:0]  row_hi, col_hi;
   logic [COORD_W-1:0] rad8;
   logic               edge_row;
   sqd_mem_ctl_type    mem_ctl;
   logic [PIXEL_W-1:0] rd_data;

   always_comb begin
      if (side_ff == '0) begin
         side_eff = SIDE_W'(1);
      end else if (side_ff > SIDE_RESET) begin
         side_eff = SIDE_RESET;
      end else begin
         side_eff = side_ff;
      end
   end

   assign rad8   = COORD_W'(cmd_ff.radius);
   assign row_hi = {1'b0, cmd_ff.center_row} + {1'b0, rad8};
   assign col_hi = {1'b0, cmd_ff.center_col} + {1'b0, rad8};
   assign reject = (cmd_ff.center_row < rad8) || (cmd_ff.center_col < rad8) ||
                   (row_hi >= side_eff) || (col_hi >= side_eff);
   assign edge_row = (i_ff == r0_ff) || (i_ff == r1_ff);

   always_comb begin
      state_in   = state_ff;
      r0_in      = r0_ff;
      r1_in      = r1_ff;
      c0_in      = c0_ff;
      c1_in      = c1_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      outline_in = outline_ff;
      status_in  = status_ff;
      pix_sel_in = pix_sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in  = STATUS_DONE;
            pix_sel_in = 1'b0;
            state_in   = S_RESP;
            unique case (cmd_ff.kind)
               KIND_CLEAR: begin
                  r0_in      = '0;
                  c0_in      = '0;
                  r1_in      = COORD_W'(side_eff - SIDE_W'(1));
                  c1_in      = COORD_W'(side_eff - SIDE_W'(1));
                  i_in       = '0;
                  j_in       = '0;
                  outline_in = 1'b0;
                  state_in   = S_WALK;
               end
               KIND_DRAW: begin
                  r0_in = cmd_ff.center_row - rad8;
                  c0_in = cmd_ff.center_col - rad8;
                  r1_in = row_hi[COORD_W-1:0];
                  c1_in = col_hi[COORD_W-1:0];
                  i_in  = cmd_ff.center_row - rad8;
                  j_in  = cmd_ff.center_col - rad8;
                  outline_in = (cmd_ff.style == STYLE_OUTLINE);
                  if (reject) begin
                     status_in = STATUS_REJECT;
                  end else if (cmd_ff.style == STYLE_OUTLINE ||
                               cmd_ff.style == STYLE_FILL) begin
                     state_in = S_WALK;
                  end
               end
               KIND_READ: begin
                  if ({1'b0, cmd_ff.center_row} >= side_eff ||
                      {1'b0, cmd_ff.center_col} >= side_eff) begin
                     status_in = STATUS_REJECT;
                  end else begin
                     pix_sel_in = 1'b1;
                     state_in   = S_READ;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_WALK: begin
            if (j_ff == c1_ff) begin
               if (i_ff == r1_ff) begin
                  state_in = S_RESP;
               end else begin
                  i_in = i_ff + COORD_W'(1);
                  j_in = c0_ff;
               end
            end else if (outline_ff && !edge_row) begin
               j_in = c1_ff;
            end else begin
               j_in = j_ff + COORD_W'(1);
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         side_ff  <= SIDE_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            side_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         cmd_ff <= req_item;
      end
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      c0_ff      <= c0_in;
      c1_ff      <= c1_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      outline_ff <= outline_in;
      status_ff  <= status_in;
      pix_sel_ff <= pix_sel_in;
   end

   always_comb begin
      mem_ctl.wr_en   = (state_ff == S_WALK);
      mem_ctl.wr_addr = {i_ff, j_ff};
      mem_ctl.wr_data = cmd_ff.color;
      mem_ctl.rd_en   = (state_ff == S_READ);
      mem_ctl.rd_addr = {cmd_ff.center_row, cmd_ff.center_col};
   end

   sqd_image_mem u_image_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_data (rd_data)
   );

   assign busy            = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_strobe      = (state_ff == S_RESP);
   assign rsp_item.status = status_ff;
   assign rsp_item.pixel  = pix_sel_ff ? rd_data : '0;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("response strobe not followed by idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted item did not raise busy");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> i_ff >= r0_ff && i_ff <= r1_ff && j_ff >= c0_ff && j_ff <= c1_ff)
      else $error("pixel write outside square bounds");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |-> !mem_ctl.wr_en)
      else $error("read and write overlap");

endmodule

### tb/sv/sqd_draw_checker.sv
`timescale 1ns / 1ps

module sqd_draw_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  sqd_pkg::sqd_req_type       req_item,
   input  logic                       rsp_strobe,
   input  sqd_pkg::sqd_rsp_type       rsp_item,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [sqd_pkg::SIDE_W-1:0] csr_data,
   output int                         error_total,
   output int                         answers_pending,
   output int                         answers_checked
);
   import sqd_pkg::*;

   logic [PIXEL_W-1:0] image_mem [MAX_SIDE*MAX_SIDE];
   logic [SIDE_W-1:0]  side_reg = SIDE_RESET;
   sqd_rsp_type        answer_q [$];
   int                 n_errors = 0;
   int                 n_checked = 0;
   int                 n_pending = 0;

   assign error_total     = n_errors;
   assign answers_pending = n_pending;
   assign answers_checked = n_checked;

   // A side of zero acts as one, and a side above the store acts as the full store.
   function automatic int unsigned image_side();
      if (side_reg == '0) return 1;
      if (side_reg > SIDE_W'(MAX_SIDE)) return MAX_SIDE;
      return side_reg;
   endfunction

   function automatic void paint(int unsigned row, int unsigned col, logic [7:0] color);
      image_mem[row * MAX_SIDE + col] = color;
   endfunction

   function automatic sqd_rsp_type paint_and_answer(sqd_req_type cmd);
      sqd_rsp_type ans;
      int unsigned s;
      int unsigned row;
      int unsigned col;
      int unsigned rad;
      int unsigned i;
      int unsigned j;
      s          = image_side();
      row        = cmd.center_row;
      col        = cmd.center_col;
      rad        = cmd.radius;
      ans.status = STATUS_DONE;
      ans.pixel  = '0;
      case (cmd.kind)
         KIND_CLEAR: begin
            for (i = 0; i < s; i++)
               for (j = 0; j < s; j++)
                  paint(i, j, cmd.color);
         end
         KIND_DRAW: begin
            if (row < rad || col < rad || row + rad >= s || col + rad >= s) begin
               ans.status = STATUS_REJECT;
            end else if (cmd.style == STYLE_OUTLINE) begin
               for (j = col - rad; j <= col + rad; j++) begin
                  paint(row - rad, j, cmd.color);
                  paint(row + rad, j, cmd.color);
               end
               for (i = row - rad; i <= row + rad; i++) begin
                  paint(i, col - rad, cmd.color);
                  paint(i, col + rad, cmd.color);
               end
            end else if (cmd.style == STYLE_FILL) begin
               for (i = row - rad; i <= row + rad; i++)
                  for (j = col - rad; j <= col + rad; j++)
                     paint(i, j, cmd.color);
            end
         end
         KIND_READ: begin
            if (row >= s || col >= s) begin
               ans.status = STATUS_REJECT;
            end else begin
               ans.pixel = image_mem[row * MAX_SIDE + col];
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      sqd_rsp_type want;
      if (reset) begin
         answer_q.delete();
         side_reg = SIDE_RESET;
      end else begin
         if (rsp_strobe) begin
            if (answer_q.size() == 0) begin
               $error("response with no item outstanding: status %0d, pixel %0d",
                      rsp_item.status, rsp_item.pixel);
               n_errors++;
            end else begin
               want = answer_q.pop_front();
               n_checked++;
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  n_errors++;
               end
               if (rsp_item.pixel !== want.pixel) begin
                  $error("pixel: expected %0d, got %0d", want.pixel, rsp_item.pixel);
                  n_errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            side_reg = csr_data;
         end
         if (start && !busy) begin
            answer_q.push_back(paint_and_answer(req_item));
         end
      end
      n_pending = answer_q.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import sqd_pkg::*;

   localparam logic [1:0] KIND_UNUSED    = 2'd3;
   localparam logic [1:0] STYLE_NONE     = 2'd0;
   localparam logic [1:0] STYLE_SPARE    = 2'd3;
   localparam int         CLEAR_SIDE_MAX = 64;
   localparam int         BIG_SIDE_RAD   = 12;
   localparam int         N_PHASES       = 8;
   localparam int         RANDOM_SIDE    = -1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   sqd_req_type       req_item = '0;
   logic              csr_valid = 1'b0;
   logic [SIDE_W-1:0] csr_data = '0;
   logic              busy;
   logic              rsp_strobe;
   sqd_rsp_type       rsp_item;
   logic              csr_ready;
   int                errors;
   int                pending;
   int                checked;

   int unsigned side_now = MAX_SIDE;
   int unsigned idle_pct = 0;
   int          n_clear = 0;
   int          n_draw = 0;
   int          n_read = 0;
   int          n_unused = 0;
   int          n_sides = 0;

   int phase_side [N_PHASES] = '{16, 1, 0, 511, 2, RANDOM_SIDE, 255, 37};
   int phase_idle [N_PHASES] = '{0, 68, 23, 0, 68, 23, 0, 68};
   int phase_len  [N_PHASES] = '{16, 8, 6, 10, 10, 20, 10, 20};

   square_draw_framebuffer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   sqd_draw_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_item        (req_item),
      .rsp_strobe      (rsp_strobe),
      .rsp_item        (rsp_item),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .error_total     (errors),
      .answers_pending (pending),
      .answers_checked (checked)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic sqd_req_type make_cmd(logic [1:0] kind, int unsigned row,
                                            int unsigned col, int unsigned rad,
                                            logic [1:0] style, logic [7:0] color);
      sqd_req_type cmd;
      cmd.kind       = kind;
      cmd.center_row = 8'(row);
      cmd.center_col = 8'(col);
      cmd.radius     = 7'(rad);
      cmd.style      = style;
      cmd.color      = color;
      return cmd;
   endfunction

   // Most draws fit inside the image; the rest of the mix is reads, clears and raw noise.
   function automatic sqd_req_type random_cmd(bit allow_big);
      sqd_req_type cmd;
      int unsigned pick;
      int unsigned rad_max;
      int unsigned rad;
      cmd = make_cmd(2'($urandom), $urandom_range(255), $urandom_range(255),
                     $urandom_range(127), 2'($urandom), 8'($urandom));
      pick    = $urandom_range(99);
      rad_max = (side_now - 1) / 2;
      if (side_now > CLEAR_SIDE_MAX && !allow_big && rad_max > BIG_SIDE_RAD) begin
         rad_max = BIG_SIDE_RAD;
      end
      if (pick < 15) begin
         cmd.kind = KIND_CLEAR;
      end else if (pick < 60) begin
         rad            = $urandom_range(rad_max);
         cmd.kind       = KIND_DRAW;
         cmd.radius     = 7'(rad);
         cmd.center_row = 8'($urandom_range(side_now - 1 - rad, rad));
         cmd.center_col = 8'($urandom_range(side_now - 1 - rad, rad));
         if ($urandom_range(9) != 0) begin
            cmd.style = ($urandom_range(1) == 0) ? STYLE_OUTLINE : STYLE_FILL;
         end
      end else if (pick < 90) begin
         cmd.kind = KIND_READ;
         if ($urandom_range(5) != 0) begin
            cmd.center_row = 8'($urandom_range(side_now - 1));
            cmd.center_col = 8'($urandom_range(side_now - 1));
         end
      end
      if (cmd.kind == KIND_CLEAR && side_now > CLEAR_SIDE_MAX) begin
         cmd.kind = KIND_READ;
      end
      return cmd;
   endfunction

   task automatic wait_idle();
      @(negedge clock) start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_side(int value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= SIDE_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
      side_now = (value == 0) ? 1 : ((value > MAX_SIDE) ? MAX_SIDE : value);
      n_sides++;
   endtask

   task automatic send(sqd_req_type cmd);
      while ($urandom_range(99) < idle_pct) @(negedge clock) start <= 1'b0;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= cmd;
      do @(posedge clock); while (busy);
      case (cmd.kind)
         KIND_CLEAR: n_clear++;
         KIND_DRAW:  n_draw++;
         KIND_READ:  n_read++;
         default:    n_unused++;
      endcase
   endtask

   initial begin
      int p;
      int k;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // The first item writes the whole store, so no later read can hit an unwritten pixel.
      send(make_cmd(KIND_CLEAR, 0, 0, 0, STYLE_NONE, 8'h5A));
      send(make_cmd(KIND_READ, 0, 0, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_DRAW, 127, 127, 127, STYLE_FILL, 8'hFF));
      send(make_cmd(KIND_READ, 254, 254, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_READ, 255, 255, 127, STYLE_SPARE, 8'hFF));
      send(make_cmd(KIND_DRAW, 128, 128, 100, STYLE_OUTLINE, 8'h00));
      send(make_cmd(KIND_READ, 28, 200, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_READ, 228, 28, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_READ, 130, 228, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_READ, 129, 129, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_DRAW, 5, 5, 0, STYLE_OUTLINE, 8'h11));
      send(make_cmd(KIND_DRAW, 6, 6, 0, STYLE_FILL, 8'h22));
      send(make_cmd(KIND_READ, 5, 5, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_READ, 6, 6, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_DRAW, 10, 10, 2, STYLE_NONE, 8'h33));
      send(make_cmd(KIND_DRAW, 10, 10, 2, STYLE_SPARE, 8'h33));
      send(make_cmd(KIND_READ, 10, 10, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_DRAW, 0, 0, 1, STYLE_FILL, 8'h44));
      send(make_cmd(KIND_DRAW, 255, 128, 1, STYLE_FILL, 8'h44));
      send(make_cmd(KIND_DRAW, 128, 255, 1, STYLE_OUTLINE, 8'h44));
      send(make_cmd(KIND_DRAW, 126, 127, 127, STYLE_FILL, 8'h44));
      send(make_cmd(KIND_DRAW, 127, 127, 127, STYLE_OUTLINE, 8'h80));
      send(make_cmd(KIND_READ, 0, 254, 0, STYLE_NONE, 8'h00));
      send(make_cmd(KIND_UNUSED, 255, 255, 127, STYLE_SPARE, 8'hFF));

      for (p = 0; p < N_PHASES; p++) begin
         set_side((phase_side[p] == RANDOM_SIDE) ? $urandom_range(48, 3) : phase_side[p]);
         idle_pct = phase_idle[p];
         for (k = 0; k < phase_len[p]; k++) begin
            if ($urandom_range(11) == 0) begin
               wait_idle();
            end
            send(random_cmd(k == 0));
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Covered %0d items: %0d clears, %0d squares, %0d pixel reads, %0d unused kind.",
               n_clear + n_draw + n_read + n_unused, n_clear, n_draw, n_read, n_unused);
      $display("Image side changed %0d times; %0d responses compared.", n_sides, checked);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d responses still outstanding.", pending);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### files.f
src/sqd_pkg.sv
src/sqd_image_mem.sv
src/square_draw_framebuffer_top.sv
tb/sv/sqd_draw_checker.sv
tb/sv/tb.sv
